/* hdl/dla_pkg.sv */
package dla_pkg;

  // Table geometry
  localparam int LEASE_ENTRIES = 8;
  localparam int IDX_W = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(LEASE_ENTRIES + 1) + 1;
  localparam int PRB_W = $clog2(LEASE_ENTRIES + 2) + 1;

  localparam int MAC_W = 48;
  localparam int IP_W  = 32;
  localparam int ENT_W = MAC_W + IP_W;

  // Register map (index = paddr[4:2])
  localparam logic [2:0] REG_SERVER_IP  = 3'd0;
  localparam logic [2:0] REG_SUBNET     = 3'd1;
  localparam logic [2:0] REG_FIRST_HOST = 3'd2;
  localparam logic [2:0] REG_POOL_SIZE  = 3'd3;
  localparam logic [2:0] REG_ENHANCED   = 3'd4;

  localparam logic [31:0] DEF_SERVER = 32'hC0A8_0101;
  localparam logic [31:0] DEF_MASK   = 32'hFFFF_FF00;
  localparam logic [31:0] DEF_FIRST  = 32'd100;
  localparam logic [15:0] DEF_SIZE   = 16'd101;

  // Message kinds
  localparam logic [7:0] KIND_DISCOVER = 8'd1;
  localparam logic [7:0] KIND_REQUEST  = 8'd3;

  // Reply kinds
  localparam logic [1:0] RPL_OFFER = 2'd1;
  localparam logic [1:0] RPL_ACK   = 2'd2;
  localparam logic [1:0] RPL_NAK   = 2'd3;

  // NAK reasons
  localparam logic [1:0] NAK_NONE   = 2'd0;
  localparam logic [1:0] NAK_SUBNET = 2'd1;
  localparam logic [1:0] NAK_POOL   = 2'd2;
  localparam logic [1:0] NAK_IN_USE = 2'd3;

  // FNV-1a
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

endpackage

/* hdl/dla_in_if.sv */
interface dla_in_if;
  import dla_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       kind;
  logic [MAC_W-1:0] client_mac;
  logic             has_requested_ip;
  logic [31:0]      requested_ip;
  logic             has_srv_id;
  logic [31:0]      srv_id;

  modport source (output valid, kind, client_mac, has_requested_ip, requested_ip,
                  has_srv_id, srv_id, input ready);
  modport sink   (input valid, kind, client_mac, has_requested_ip, requested_ip,
                  has_srv_id, srv_id, output ready);
endinterface

/* hdl/dla_out_if.sv */
interface dla_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [31:0] assigned_ip;
  logic [1:0]  nak_reason;

  modport source (output valid, reply_kind, assigned_ip, nak_reason, input ready);
  modport sink   (input valid, reply_kind, assigned_ip, nak_reason, output ready);
endinterface

/* hdl/dhcp_lease_allocator.sv */
// DHCPv4 lease allocator. Takes one parsed client message at a time and
// returns at most one reply (offer, ack or nak). Leases live in a small
// synchronous table memory read one entry per cycle; each lookup walks the
// whole table. A reply that needs no lookup (simple-mode ack of an in-pool
// address, subnet or pool nak) skips the table walk. An enhanced-mode
// allocation adds FNV-1a hashing of the MAC, a bit-serial modulo by the pool
// size and up to LEASE_ENTRIES+1 probes, each a further table walk. Messages
// of other kinds, and enhanced-mode requests naming another server, finish
// without a reply. The block returns to idle after each message before the
// next transfer, and the next message is taken only once the previous reply
// has moved into the output register. The user must write configuration
// over the APB port only while idle; the block itself does not enforce it.
module dhcp_lease_allocator
  import dla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dla_in_if.sink      in_if,
  dla_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // State codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_POOL   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_ALLOC  = 4'd4;
  localparam logic [3:0] S_HASH   = 4'd5;
  localparam logic [3:0] S_MOD    = 4'd6;
  localparam logic [3:0] S_PROBE  = 4'd7;
  localparam logic [3:0] S_PCHK   = 4'd8;
  localparam logic [3:0] S_SIMPLE = 4'd9;
  localparam logic [3:0] S_REQCHK = 4'd10;
  localparam logic [3:0] S_RECORD = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  localparam logic [1:0] RET_ALLOC = 2'd0;
  localparam logic [1:0] RET_PROBE = 2'd1;
  localparam logic [1:0] RET_REQ   = 2'd2;

  // Configuration registers
  logic [31:0] server_r, mask_r, first_r;
  logic [15:0] size_r;
  logic        enh_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_r <= DEF_SERVER;
      mask_r   <= DEF_MASK;
      first_r  <= DEF_FIRST;
      size_r   <= DEF_SIZE;
      enh_r    <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_SERVER_IP:  server_r <= pwdata;
        REG_SUBNET:     mask_r   <= pwdata;
        REG_FIRST_HOST: first_r  <= pwdata;
        REG_POOL_SIZE:  size_r   <= pwdata[15:0];
        REG_ENHANCED:   enh_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SERVER_IP:  prdata = server_r;
      REG_SUBNET:     prdata = mask_r;
      REG_FIRST_HOST: prdata = first_r;
      REG_POOL_SIZE:  prdata = {16'd0, size_r};
      REG_ENHANCED:   prdata = {31'd0, enh_r};
      default:        prdata = 32'd0;
    endcase
  end

  // Effective server / mask and pool range
  logic [31:0] srv_eff, mask_eff, net, hmask, hs, st_c, en_c, sz_c;

  always_comb begin
    srv_eff  = (server_r != 32'd0) ? server_r : DEF_SERVER;
    mask_eff = (mask_r != 32'd0) ? mask_r : DEF_MASK;
    hmask    = ~mask_eff;
    net      = srv_eff & mask_eff;
    hs       = first_r & hmask;
    if (hs == 32'd0) hs = 32'd1;
    sz_c     = (size_r != 16'd0) ? {16'd0, size_r} : 32'd1;
    st_c     = net | hs;
    en_c     = st_c + sz_c - 32'd1;
    if (((en_c & mask_eff) != net) || (en_c > (net | hmask))) en_c = net | hmask;
  end

  // Latched message
  logic [7:0]       kind_r;
  logic [MAC_W-1:0] mac_r;
  logic             has_req_r, has_sid_r;
  logic [31:0]      req_r, sid_r;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] s_r, e_r;
  logic [15:0] n_r;

  function automatic logic in_pool(input logic [31:0] ip, input logic [31:0] s,
                                   input logic [31:0] e);
    return (ip >= s) && (ip <= e);
  endfunction

  // Lease table memory and valid bits
  logic [ENT_W-1:0] mem [LEASE_ENTRIES];
  logic [LEASE_ENTRIES-1:0] valid_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, rd_addr, rd_idx_r;
  logic [ENT_W-1:0] mem_wdata, rdata_r;
  logic             rd_issue, rd_vld_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r  <= mem[rd_addr];
    rd_idx_r <= rd_addr;
  end

  // Free entry search over valid bits
  logic             any_free;
  logic [IDX_W-1:0] free_idx;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = LEASE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Scan bookkeeping
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       ret_r;
  logic [31:0]      tgt_r;
  logic             mac_found_r, ip_found_r, ip_mac_eq_r;
  logic [IDX_W-1:0] mac_idx_r;
  logic [31:0]      mac_ip_r;

  // Hash / modulo / probe
  logic [31:0]      h_r, dvd_r;
  logic [MAC_W-1:0] hm_r;
  logic [16:0]      rem_r;
  logic [5:0]       step_r;
  logic [15:0]      idx_r;
  logic [PRB_W-1:0] j_r;
  logic [31:0]      cand_r;
  logic [31:0]      h_prod;
  logic [16:0]      rem_sh, rem_nxt;

  // only the low 32 bits of the FNV product are kept
  assign h_prod  = (h_r ^ {24'd0, hm_r[MAC_W-1 -: 8]}) * FNV_PRIME;
  assign rem_sh  = {rem_r[15:0], dvd_r[31]};
  assign rem_nxt = (rem_sh >= {1'b0, n_r}) ? rem_sh - {1'b0, n_r} : rem_sh;

  logic        rec_after_r;
  logic [1:0]  rk_r, why_r;
  logic [31:0] res_ip_r, next_r;
  logic        out_valid_r;
  logic [1:0]  out_rk_r, out_why_r;
  logic [31:0] out_ip_r;

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.reply_kind  = out_rk_r;
  assign out_if.assigned_ip = out_ip_r;
  assign out_if.nak_reason  = out_why_r;

  assign rd_issue = (state_r == S_SCAN) && (cnt_r < CNT_W'(LEASE_ENTRIES));
  assign rd_addr  = cnt_r[IDX_W-1:0];

  // Simple-mode allocation values
  logic [31:0] nh, nh_inc;
  assign nh     = (next_r == 32'd0) ? s_r : next_r;
  assign nh_inc = nh + 32'd1;

  // Record target
  logic [IDX_W-1:0] rec_idx;
  assign rec_idx = mac_found_r ? mac_idx_r : (any_free ? free_idx : '0);

  // Probe step values
  logic [15:0]      idx_inc;
  logic [PRB_W-1:0] j_inc;
  assign idx_inc = (idx_r + 16'd1 == n_r) ? 16'd0 : idx_r + 16'd1;
  assign j_inc   = j_r + PRB_W'(1);

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_if.valid) state_nxt = S_POOL;
      S_POOL:   state_nxt = S_DISP;
      S_DISP: begin
        if (kind_r == KIND_DISCOVER) state_nxt = S_SCAN;
        else if (kind_r != KIND_REQUEST) state_nxt = S_IDLE;
        else if (!enh_r) state_nxt = (has_req_r && in_pool(req_r, s_r, e_r)) ? S_DONE : S_SCAN;
        else if (has_sid_r && (sid_r != srv_eff)) state_nxt = S_IDLE;
        else if (!has_req_r) state_nxt = S_SCAN;
        else if ((req_r & mask_eff) != (srv_eff & mask_eff)) state_nxt = S_DONE;
        else if (!in_pool(req_r, s_r, e_r)) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_r == CNT_W'(LEASE_ENTRIES)) begin
          unique case (ret_r)
            RET_ALLOC: state_nxt = S_ALLOC;
            RET_PROBE: state_nxt = S_PCHK;
            default:   state_nxt = S_REQCHK;
          endcase
        end
      end
      S_ALLOC: begin
        if (mac_found_r && in_pool(mac_ip_r, s_r, e_r))
          state_nxt = rec_after_r ? S_RECORD : S_DONE;
        else if (!enh_r) state_nxt = S_SIMPLE;
        else if (n_r == 16'd0) state_nxt = rec_after_r ? S_RECORD : S_DONE;
        else state_nxt = S_HASH;
      end
      S_HASH:   if (step_r == 6'd5) state_nxt = S_MOD;
      S_MOD:    if (step_r == 6'd31) state_nxt = S_PROBE;
      S_PROBE:  state_nxt = S_SCAN;
      S_PCHK: begin
        if (!ip_found_r) state_nxt = rec_after_r ? S_RECORD : S_DONE;
        else if (({{(16 - PRB_W){1'b0}}, j_inc} < n_r) && (j_inc <= PRB_W'(LEASE_ENTRIES)))
          state_nxt = S_PROBE;
        else state_nxt = rec_after_r ? S_RECORD : S_DONE;
      end
      S_SIMPLE: state_nxt = S_DONE;
      S_REQCHK: state_nxt = (ip_found_r && !ip_mac_eq_r) ? S_DONE : S_RECORD;
      S_RECORD: state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_if.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = {mac_r, nh};
    if (state_r == S_SIMPLE && !(mac_found_r && in_pool(mac_ip_r, s_r, e_r)) && any_free) begin
      mem_we = 1'b1;
    end else if (state_r == S_RECORD) begin
      mem_we    = 1'b1;
      mem_waddr = rec_idx;
      mem_wdata = {mac_r, res_ip_r};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      next_r      <= 32'd0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_issue;
      if (mem_we) valid_r[mem_waddr] <= 1'b1;
      if (state_r == S_SIMPLE) begin
        if (any_free) next_r <= (nh_inc > e_r) ? s_r : nh_inc;
        else next_r <= nh;
      end
      // output register: load a new reply, else drop the one just transferred
      if (state_r == S_DONE && (!out_valid_r || out_if.ready)) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        kind_r    <= in_if.kind;
        mac_r     <= in_if.client_mac;
        has_req_r <= in_if.has_requested_ip;
        req_r     <= in_if.requested_ip;
        has_sid_r <= in_if.has_srv_id;
        sid_r     <= in_if.srv_id;
      end
      S_POOL: begin
        s_r <= st_c;
        e_r <= en_c;
        n_r <= (en_c >= st_c) ? 16'(en_c - st_c + 32'd1) : 16'd0;
      end
      S_DISP: begin
        cnt_r       <= '0;
        mac_found_r <= 1'b0;
        ip_found_r  <= 1'b0;
        rec_after_r <= 1'b0;
        why_r       <= NAK_NONE;
        rk_r        <= (kind_r == KIND_DISCOVER) ? RPL_OFFER : RPL_ACK;
        res_ip_r    <= req_r;
        tgt_r       <= req_r;
        ret_r       <= RET_ALLOC;
        if (kind_r == KIND_REQUEST && enh_r) begin
          if (!has_req_r) rec_after_r <= 1'b1;
          else if ((req_r & mask_eff) != (srv_eff & mask_eff)) begin
            rk_r <= RPL_NAK; why_r <= NAK_SUBNET; res_ip_r <= 32'd0;
          end else if (!in_pool(req_r, s_r, e_r)) begin
            rk_r <= RPL_NAK; why_r <= NAK_POOL; res_ip_r <= 32'd0;
          end else ret_r <= RET_REQ;
        end
      end
      S_SCAN: begin
        if (rd_issue) cnt_r <= cnt_r + CNT_W'(1);
        if (rd_vld_r && valid_r[rd_idx_r]) begin
          if (!mac_found_r && rdata_r[ENT_W-1 -: MAC_W] == mac_r) begin
            mac_found_r <= 1'b1;
            mac_idx_r   <= rd_idx_r;
            mac_ip_r    <= rdata_r[IP_W-1:0];
          end
          if (!ip_found_r && rdata_r[IP_W-1:0] == tgt_r) begin
            ip_found_r  <= 1'b1;
            ip_mac_eq_r <= (rdata_r[ENT_W-1 -: MAC_W] == mac_r);
          end
        end
      end
      S_ALLOC: begin
        res_ip_r <= (mac_found_r && in_pool(mac_ip_r, s_r, e_r)) ? mac_ip_r : s_r;
        h_r      <= FNV_BASIS;
        hm_r     <= mac_r;
        step_r   <= 6'd0;
      end
      S_HASH: begin
        h_r    <= h_prod;
        hm_r   <= {hm_r[MAC_W-9:0], 8'd0};
        step_r <= (step_r == 6'd5) ? 6'd0 : step_r + 6'd1;
        dvd_r  <= h_prod;
        rem_r  <= 17'd0;
      end
      S_MOD: begin
        dvd_r  <= {dvd_r[30:0], 1'b0};
        rem_r  <= rem_nxt;
        step_r <= step_r + 6'd1;
        if (step_r == 6'd31) begin
          idx_r <= rem_nxt[15:0];
          j_r   <= '0;
        end
      end
      S_PROBE: begin
        cand_r      <= s_r + {16'd0, idx_r};
        tgt_r       <= s_r + {16'd0, idx_r};
        ret_r       <= RET_PROBE;
        cnt_r       <= '0;
        mac_found_r <= 1'b0;
        ip_found_r  <= 1'b0;
      end
      S_PCHK: begin
        if (!ip_found_r) res_ip_r <= cand_r;
        j_r   <= j_inc;
        idx_r <= idx_inc;
      end
      S_SIMPLE: res_ip_r <= any_free ? nh : s_r;
      S_REQCHK: begin
        if (ip_found_r && !ip_mac_eq_r) begin
          rk_r <= RPL_NAK; why_r <= NAK_IN_USE; res_ip_r <= 32'd0;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_rk_r  <= rk_r;
          out_ip_r  <= res_ip_r;
          out_why_r <= why_r;
        end
      end
      default: ;
    endcase
  end

endmodule

/* sim/dla_checker.sv */
`timescale 1ns / 1ps

// Watches the message, reply and register buses, keeps its own copy of the
// lease table and computes the reply expected for every accepted message.
module dla_checker
  import dla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dla_in_if           msg_bus,
  dla_out_if          reply_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] ip;
    logic [1:0]  why;
  } reply_t;

  reply_t replies_due[$];

  // shadow registers
  logic [31:0] srv_reg, mask_reg, first_reg;
  logic [15:0] size_reg;
  logic        enh_reg;

  // shadow lease table
  logic        lease_vld [LEASE_ENTRIES];
  logic [47:0] lease_mac [LEASE_ENTRIES];
  logic [31:0] lease_ip  [LEASE_ENTRIES];
  logic [31:0] next_host;

  assign pending = replies_due.size();

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [31:0] srv_eff();
    return (srv_reg != 0) ? srv_reg : DEF_SERVER;
  endfunction

  function automatic logic [31:0] mask_eff();
    return (mask_reg != 0) ? mask_reg : DEF_MASK;
  endfunction

  function automatic void pool_bounds(output logic [31:0] s, output logic [31:0] e);
    logic [31:0] m, hm, net, hs, sz;
    m   = mask_eff();
    hm  = ~m;
    net = srv_eff() & m;
    hs  = first_reg & hm;
    if (hs == 0) hs = 1;
    sz  = (size_reg != 0) ? {16'd0, size_reg} : 32'd1;
    s   = net | hs;
    e   = s + sz - 32'd1;
    if ((e & m) != net || e > (net | hm)) e = net | hm;
  endfunction

  function automatic bit pool_has(logic [31:0] ip);
    logic [31:0] s, e;
    pool_bounds(s, e);
    return ip >= s && ip <= e;
  endfunction

  function automatic int slot_of_mac(logic [47:0] mac);
    for (int i = 0; i < LEASE_ENTRIES; i++)
      if (lease_vld[i] && lease_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic int slot_of_ip(logic [31:0] ip);
    for (int i = 0; i < LEASE_ENTRIES; i++)
      if (lease_vld[i] && lease_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic logic [31:0] mac_hash(logic [47:0] mac);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < 6; i++) begin
      h = h ^ {24'd0, mac[47-8*i -: 8]};
      h = h * FNV_PRIME;
    end
    return h;
  endfunction

  // address choice; simple mode also takes a table slot
  function automatic logic [31:0] pick_addr(logic [47:0] mac);
    int          k;
    logic [31:0] s, e, n, off, cand, ip, j;
    k = slot_of_mac(mac);
    if (k >= 0 && pool_has(lease_ip[k])) return lease_ip[k];
    pool_bounds(s, e);
    n = (e >= s) ? e - s + 32'd1 : 32'd0;
    if (enh_reg) begin
      if (n != 0) begin
        off = mac_hash(mac) % n;
        for (j = 0; j < n && j <= LEASE_ENTRIES; j++) begin
          cand = s + ((off + j) % n);
          if (slot_of_ip(cand) < 0) return cand;
        end
      end
      return s;
    end
    if (next_host == 0) next_host = s;
    for (int i = 0; i < LEASE_ENTRIES; i++) begin
      if (!lease_vld[i]) begin
        ip           = next_host;
        lease_vld[i] = 1'b1;
        lease_mac[i] = mac;
        lease_ip[i]  = ip;
        next_host    = next_host + 32'd1;
        if (next_host > e) next_host = s;
        return ip;
      end
    end
    return s;
  endfunction

  function automatic void bind_lease(logic [47:0] mac, logic [31:0] ip);
    int k;
    k = slot_of_mac(mac);
    if (k >= 0) begin
      lease_ip[k] = ip;
      return;
    end
    for (int i = 0; i < LEASE_ENTRIES; i++) begin
      if (!lease_vld[i]) begin
        lease_vld[i] = 1'b1;
        lease_mac[i] = mac;
        lease_ip[i]  = ip;
        return;
      end
    end
    lease_vld[0] = 1'b1;
    lease_mac[0] = mac;
    lease_ip[0]  = ip;
  endfunction

  // returns 1 when the message produces a reply
  function automatic bit decide_reply(logic [7:0] kind, logic [47:0] mac, logic has_req,
                                      logic [31:0] req, logic has_sid, logic [31:0] sid,
                                      output reply_t r);
    int          k;
    logic [31:0] srv, m;
    r.kind = RPL_ACK;
    r.ip   = 0;
    r.why  = NAK_NONE;
    if (kind == KIND_DISCOVER) begin
      r.kind = RPL_OFFER;
      r.ip   = pick_addr(mac);
      return 1;
    end
    if (kind != KIND_REQUEST) return 0;
    if (!enh_reg) begin
      r.ip = (has_req && pool_has(req)) ? req : pick_addr(mac);
      return 1;
    end
    srv = srv_eff();
    m   = mask_eff();
    if (has_sid && sid != srv) return 0;
    if (!has_req) begin
      r.ip = pick_addr(mac);
      bind_lease(mac, r.ip);
    end else if ((req & m) != (srv & m)) begin
      r.kind = RPL_NAK;
      r.why  = NAK_SUBNET;
    end else if (!pool_has(req)) begin
      r.kind = RPL_NAK;
      r.why  = NAK_POOL;
    end else begin
      k = slot_of_ip(req);
      if (k >= 0 && lease_mac[k] != mac) begin
        r.kind = RPL_NAK;
        r.why  = NAK_IN_USE;
      end else begin
        r.ip = req;
        bind_lease(mac, req);
      end
    end
    return 1;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    reply_t got, want;
    if (!rst_n) begin
      srv_reg   = DEF_SERVER;
      mask_reg  = DEF_MASK;
      first_reg = DEF_FIRST;
      size_reg  = DEF_SIZE;
      enh_reg   = 1'b0;
      next_host = 0;
      for (int i = 0; i < LEASE_ENTRIES; i++) begin
        lease_vld[i] = 1'b0;
        lease_mac[i] = 0;
        lease_ip[i]  = 0;
      end
      replies_due.delete();
    end else begin
      // reply transfer
      if (reply_bus.valid && reply_bus.ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected reply kind=%0d ip=%h",
                                    reply_bus.reply_kind, reply_bus.assigned_ip));
        end else begin
          want = replies_due.pop_front();
          if (reply_bus.reply_kind !== want.kind)
            report_mismatch($sformatf("reply_kind %0d, want %0d",
                                      reply_bus.reply_kind, want.kind));
          if (reply_bus.assigned_ip !== want.ip)
            report_mismatch($sformatf("assigned_ip %h, want %h",
                                      reply_bus.assigned_ip, want.ip));
          if (reply_bus.nak_reason !== want.why)
            report_mismatch($sformatf("nak_reason %0d, want %0d",
                                      reply_bus.nak_reason, want.why));
        end
      end
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SERVER_IP:  srv_reg   = pwdata;
          REG_SUBNET:     mask_reg  = pwdata;
          REG_FIRST_HOST: first_reg = pwdata;
          REG_POOL_SIZE:  size_reg  = pwdata[15:0];
          REG_ENHANCED:   enh_reg   = pwdata[0];
          default: ;
        endcase
      end
      // message transfer
      if (msg_bus.valid && msg_bus.ready) begin
        if (decide_reply(msg_bus.kind, msg_bus.client_mac, msg_bus.has_requested_ip,
                         msg_bus.requested_ip, msg_bus.has_srv_id, msg_bus.srv_id,
                         got))
          replies_due.push_back(got);
      end
    end
  end

endmodule

/* sim/tb_dhcp_lease_allocator.sv */
`timescale 1ns / 1ps

module tb_dhcp_lease_allocator;
  import dla_pkg::*;

  localparam int PHASE_ITEMS = 190;
  localparam int SETTLE      = 250;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          errors, pending;
  int          cyc;

  dla_in_if  msg_bus();
  dla_out_if reply_bus();

  dhcp_lease_allocator DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (msg_bus),
    .out_if  (reply_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dla_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_bus   (msg_bus),
    .reply_bus (reply_bus),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .errors    (errors),
    .pending   (pending)
  );

  // current settings, used to aim requested addresses
  logic [31:0] cur_srv, cur_mask, cur_first;
  logic [15:0] cur_size;
  logic [47:0] mac_set [12];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("[dhcp_lease_allocator] ERROR");
    $finish;
  end

  always @(posedge clk) cyc <= rst_n ? cyc + 1 : 0;

  // reply side: changing stall patterns plus one long hold-off
  initial begin
    int mode;
    mode = 0;
    reply_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (cyc >= 6000 && cyc < 6400)
        reply_bus.ready <= 1'b0;
      else case (mode)
        0: reply_bus.ready <= 1'b1;
        1: reply_bus.ready <= ($urandom_range(0, 9) < 7);
        default: reply_bus.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_replies();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_pool(input logic [31:0] srv, input logic [31:0] m,
                          input logic [31:0] first, input logic [15:0] size,
                          input logic enh);
    drain_replies();
    cur_srv   = (srv != 0) ? srv : DEF_SERVER;
    cur_mask  = (m != 0) ? m : DEF_MASK;
    cur_first = first;
    cur_size  = size;
    reg_write(REG_SERVER_IP, srv);
    reg_write(REG_SUBNET, m);
    reg_write(REG_FIRST_HOST, first);
    reg_write(REG_POOL_SIZE, {16'd0, size});
    reg_write(REG_ENHANCED, {31'd0, enh});
  endtask

  // one message transfer; valid stays up, the caller decides on gaps
  task automatic send_msg(input logic [7:0] kind, input logic [47:0] mac,
                          input logic has_req, input logic [31:0] req,
                          input logic has_sid, input logic [31:0] sid);
    msg_bus.valid            <= 1'b1;
    msg_bus.kind             <= kind;
    msg_bus.client_mac       <= mac;
    msg_bus.has_requested_ip <= has_req;
    msg_bus.requested_ip     <= req;
    msg_bus.has_srv_id       <= has_sid;
    msg_bus.srv_id           <= sid;
    @(posedge clk iff (msg_bus.valid && msg_bus.ready));
  endtask

  task automatic pause_sender(input int n);
    msg_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [31:0] aim_addr();
    logic [31:0] net, hs;
    net = cur_srv & cur_mask;
    hs  = cur_first & ~cur_mask;
    if (hs == 0) hs = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return (net | hs) + $urandom_range(0, 12);
      5:             return (net | hs) + cur_size + $urandom_range(0, 3) - 2;
      6, 7:          return net | ($urandom & ~cur_mask);
      8:             return cur_srv;
      default:       return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int count);
    int          burst;
    logic [7:0]  kind;
    logic [47:0] mac;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1:    kind = 8'($urandom);
        2:       kind = 8'($urandom_range(0, 4));
        default: kind = ($urandom_range(0, 1) != 0) ? KIND_DISCOVER : KIND_REQUEST;
      endcase
      mac = ($urandom_range(0, 9) < 8) ? mac_set[$urandom_range(0, 11)]
                                       : 48'({$urandom, $urandom});
      send_msg(kind, mac, $urandom_range(0, 3) != 0, aim_addr(),
               1'($urandom_range(0, 1)),
               ($urandom_range(0, 5) != 0) ? cur_srv : $urandom);
      burst--;
      if (burst == 0) begin
        pause_sender($urandom_range(1, 20));
        burst = $urandom_range(1, 12);
      end
    end
    msg_bus.valid <= 1'b0;
  endtask

  initial begin
    logic [47:0] mac_a, mac_b;
    logic [31:0] m;
    rst_n                    <= 1'b0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    msg_bus.valid            <= 1'b0;
    msg_bus.kind             <= '0;
    msg_bus.client_mac       <= '0;
    msg_bus.has_requested_ip <= 1'b0;
    msg_bus.requested_ip     <= '0;
    msg_bus.has_srv_id       <= 1'b0;
    msg_bus.srv_id           <= '0;
    cur_srv   = DEF_SERVER;
    cur_mask  = DEF_MASK;
    cur_first = DEF_FIRST;
    cur_size  = DEF_SIZE;
    mac_set[0] = '0;
    mac_set[1] = '1;
    for (int i = 2; i < 12; i++) mac_set[i] = 48'({$urandom, $urandom});
    mac_a = 48'h0011_2233_4455;
    mac_b = 48'hA0B1_C2D3_E4F5;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // simple mode at reset values: round-robin, table overflow, ignored kinds
    send_msg(KIND_DISCOVER, 48'h0, 0, 0, 0, 0);
    send_msg(KIND_DISCOVER, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
    send_msg(KIND_REQUEST, mac_a, 1, 32'hC0A8_0196, 0, 0);
    send_msg(KIND_REQUEST, mac_a, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    send_msg(8'd0, mac_b, 1, 0, 1, 0);
    send_msg(8'hFF, mac_b, 0, 0, 0, 0);
    for (int i = 0; i < 7; i++)
      send_msg(KIND_DISCOVER, {40'hCAFE_0000_00, i[7:0]}, 0, 0, 0, 0);
    pause_sender(1);

    // enhanced mode: hash probe and every NAK reason
    set_pool(DEF_SERVER, DEF_MASK, DEF_FIRST, DEF_SIZE, 1'b1);
    send_msg(KIND_DISCOVER, mac_b, 0, 0, 0, 0);
    send_msg(KIND_REQUEST, mac_b, 0, 0, 1, 32'h0A00_0001);
    send_msg(KIND_REQUEST, mac_b, 0, 0, 1, DEF_SERVER);
    send_msg(KIND_REQUEST, mac_a, 1, 32'h0A00_0064, 0, 0);
    send_msg(KIND_REQUEST, mac_a, 1, 32'hC0A8_0105, 1, DEF_SERVER);
    send_msg(KIND_REQUEST, mac_a, 1, 32'hC0A8_0170, 0, 0);
    send_msg(KIND_REQUEST, mac_a, 1, 32'hC0A8_0170, 0, 0);
    send_msg(KIND_REQUEST, mac_b, 1, 32'hC0A8_0170, 0, 0);
    send_msg(KIND_DISCOVER, mac_b, 0, 0, 0, 0);
    send_msg(KIND_REQUEST, mac_a, 1, 32'hC0A8_01FF, 0, 0);
    pause_sender(1);

    // random phases across settings, extremes included
    set_pool(DEF_SERVER, DEF_MASK, DEF_FIRST, DEF_SIZE, 1'b0);
    random_phase(PHASE_ITEMS);
    set_pool(32'h0, 32'h0, 32'h0, 16'h0, 1'b1);
    random_phase(PHASE_ITEMS);
    set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    random_phase(PHASE_ITEMS);
    set_pool({8'd10, 24'($urandom)}, 32'hFFFF_0000, $urandom, 16'hFFFF, 1'b1);
    random_phase(PHASE_ITEMS);
    m = 32'hFFFF_FFFF << $urandom_range(2, 8);
    set_pool($urandom, m, $urandom_range(0, 40), 16'($urandom_range(1, 20)), 1'b1);
    random_phase(PHASE_ITEMS);
    m = 32'hFFFF_FFFF << $urandom_range(4, 12);
    set_pool($urandom, m, $urandom, 16'($urandom_range(1, 12)), 1'b0);
    random_phase(PHASE_ITEMS);

    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("[dhcp_lease_allocator] OK");
    else
      $display("[dhcp_lease_allocator] ERROR");
    $finish;
  end

endmodule
